// ----- sv/fcd_pkg.sv -----
// Shared constants, types and helpers of the frontier cell detector.
package fcd_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int DIM_MIN     = 3;
  localparam int DIM_W       = 11;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
  localparam int OUT_W       = 10;
  localparam int OCC_W       = 2;
  localparam int COST_W      = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -2'sd1;
  localparam logic signed [OCC_W-1:0] OCC_REACHED = 2'sd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic above;
    logic cand;
    logic unk;
  } line_entry_t;

  typedef struct packed {
    logic [OUT_W-1:0] cell_row;
    logic [OUT_W-1:0] cell_col;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } result_push_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(DIM_MIN)) begin
      r = DIM_W'(DIM_MIN);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/fcd_if.sv -----
// Stream interfaces for grid cells in and frontier cells out.
interface fcd_in_if import fcd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [OCC_W-1:0]  occupancy;
  logic signed [COST_W-1:0] cell_cost;
  logic                     flush;

  modport source (output valid, output occupancy, output cell_cost, output flush,
                  input ready);
  modport sink (input valid, input occupancy, input cell_cost, input flush,
                output ready);
endinterface

interface fcd_out_if import fcd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cell_row;
  logic [OUT_W-1:0] cell_col;

  modport source (output valid, output cell_row, output cell_col, input ready);
  modport sink (input valid, input cell_row, input cell_col, output ready);
endinterface

// ----- sv/frontier_cell_detect.sv -----
// Top level of the streaming 4-neighbor frontier cell detector.
// Throughput is one cell per cycle; input stalls only while both output stages hold results.
// A cell is decided when the cell below it arrives, grid_width transfers later, and its
// result is registered into the output stage, or into the skid stage while that stage is held.
// Reset clears the counters, the left-neighbor flag and the output stages and holds the input
// off; the line store chain is not cleared and is filled by the first grid row of each frame.
module frontier_cell_detect import fcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fcd_in_if.sink                 cells_in,
  fcd_out_if.source              frontier_out
);

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             window;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [ROW_W-1:0] h_row;
  logic [DIM_W-1:0] col_ext;
  logic [DIM_W-1:0] col_plus;
  logic [COL_W-1:0] entry_idx;
  logic             fire;
  logic             space;
  logic             line_active;
  logic             data_cell;
  logic             cur_unknown;
  logic             cur_cand;
  logic             in_rows;
  logic             up;
  logic             right;
  logic             left;
  logic             hit;
  logic             shift_en;
  line_entry_t      head;
  line_entry_t      nxt;
  line_entry_t      new_entry;
  line_entry_t      chain [MAX_WIDTH];
  result_push_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(MAX_WIDTH);
      grid_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign w         = clamp_dim(grid_width, DIM_W'(MAX_WIDTH));
  assign h         = clamp_dim(grid_height, DIM_W'(MAX_HEIGHT));
  assign h_row     = ROW_W'(h);
  assign col_ext   = DIM_W'(col);
  assign col_plus  = col_ext + DIM_W'(1);
  assign entry_idx = COL_W'(DIM_W'(MAX_WIDTH) - w);

  assign cells_in.ready = space && !rst;
  assign fire           = cells_in.valid && space && !rst;

  assign line_active = col_ext < w;
  assign data_cell   = !cells_in.flush && (row < h_row);
  assign cur_unknown = data_cell && (cells_in.occupancy == OCC_UNKNOWN);
  assign cur_cand    = data_cell && (cells_in.occupancy == OCC_REACHED) &&
                       (cells_in.cell_cost <= 9'sd0);
  assign in_rows     = (row >= ROW_W'(1)) && (row <= h_row);

  assign head  = chain[MAX_WIDTH-1];
  assign nxt   = chain[MAX_WIDTH-2];
  assign up    = (row >= ROW_W'(2)) && head.above;
  assign right = (col_plus < w) && nxt.unk;
  assign left  = (col != '0) && window;
  assign hit   = line_active && in_rows && head.cand && (up || right || left || cur_unknown);

  assign new_entry.above = in_rows && head.unk;
  assign new_entry.cand  = cur_cand;
  assign new_entry.unk   = cur_unknown;
  assign shift_en        = fire && line_active;

  assign res.push          = fire && hit;
  assign res.data.cell_row = OUT_W'(h_row - row);
  assign res.data.cell_col = OUT_W'(col);

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_chain
    line_entry_t prev;
    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = chain[k-1];
    end
    fcd_line_cell u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load      (entry_idx == COL_W'(k)),
      .new_data  (new_entry),
      .prev_data (prev),
      .data      (chain[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      row    <= '0;
      window <= 1'b0;
    end else if (fire) begin
      if (row > h_row) begin
        col    <= '0;
        row    <= '0;
        window <= 1'b0;
      end else begin
        if (line_active) begin
          window <= in_rows && head.unk;
        end
        if (col_plus >= w) begin
          col <= '0;
          row <= row + ROW_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  fcd_out_skid u_out (
    .clk    (clk),
    .rst    (rst),
    .res    (res),
    .space  (space),
    .out_ch (frontier_out)
  );

endmodule

// ----- sv/fcd_line_cell.sv -----
// One column slot of the line store chain.
module fcd_line_cell import fcd_pkg::*; (
  input  logic        clk,
  input  logic        shift_en,
  input  logic        load,
  input  line_entry_t new_data,
  input  line_entry_t prev_data,
  output line_entry_t data
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data <= load ? new_data : prev_data;
    end
  end

endmodule

// ----- sv/fcd_out_skid.sv -----
// Output register with a skid stage for frontier results.
module fcd_out_skid import fcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_push_t res,
  output logic         space,
  fcd_out_if.source    out_ch
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop             = out_valid && out_ch.ready;
  assign space           = !skid_valid;
  assign out_ch.valid    = out_valid;
  assign out_ch.cell_row = out_data.cell_row;
  assign out_ch.cell_col = out_data.cell_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= res.push;
        skid_data  <= res.data;
      end else begin
        out_valid <= res.push;
        out_data  <= res.data;
      end
    end else if (res.push) begin
      skid_valid <= 1'b1;
      skid_data  <= res.data;
    end
  end

endmodule
